// File: design/ble_packet_deframer_core_defines.svh
// Assertion macros used by the deframer core.
`ifndef BLE_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define BLE_PACKET_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ble_pd_pkg.sv
package ble_pd_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 32;
  localparam int unsigned PHASE_BITS_DEF    = 16;
  localparam int unsigned CRC_TAIL_BYTES    = 3;
  localparam int unsigned WINDOW_BITS       = 79;
  localparam int unsigned PREAMBLE_PAIRS    = 8;
  localparam int unsigned PREAMBLE_RISES    = 4;
  localparam int unsigned AA_OFFSET         = 16;
  localparam int unsigned SEQ_FIRST_BYTE    = 12;
  localparam int unsigned SEQ_LAST_BYTE     = 15;
  localparam int unsigned SEQ_RANGE_BITS    = 20;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [31:0] ACCESS_ADDRESS_RESET = 32'h8e89bed6;
  localparam logic [23:0] CRC_INITIAL_RESET    = 24'hAAAAAA;
  localparam logic [5:0]  CHANNEL_INDEX_RESET  = 6'd22;
  localparam logic [5:0]  CHANNEL_MASK         = 6'h3f;
  localparam logic [24:0] CRC_POLY             = 25'h1B4C000;
  localparam logic [7:0]  LFSR_TAP             = 8'h88;
  localparam logic [7:0]  LFSR_SEED_BIT        = 8'h40;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ACCESS_ADDRESS = 2'd0,
    CFG_CRC_INITIAL    = 2'd1,
    CFG_CHANNEL_INDEX  = 2'd2
  } ble_pd_cfg_e;

  typedef struct packed {
    logic sliced;
    logic start;
  } ble_pd_slice_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic        last_of_packet;
    logic        crc_ok;
    logic [31:0] seq_number;
    logic        seq_valid;
  } ble_pd_result_t;

endpackage

// File: design/ble_pd_slicer.sv
module ble_pd_slicer #(
  parameter int unsigned PHASE_BITS = ble_pd_pkg::PHASE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [PHASE_BITS-1:0]    phase_i,
  input  logic [31:0]              access_address_i,
  output ble_pd_pkg::ble_pd_slice_t slice_o
);

  localparam int unsigned WB = ble_pd_pkg::WINDOW_BITS;

  logic [PHASE_BITS-1:0] prev_q, prev_d;
  logic [WB-1:0]         window_q, window_d;
  logic [PHASE_BITS-1:0] diff;
  logic                  sliced;
  logic [3:0]            rise_cnt;
  logic [31:0]           aa_bits;

  assign diff     = phase_i - prev_q;
  assign sliced   = (|diff) && !diff[PHASE_BITS-1];
  assign prev_d   = phase_i;
  assign window_d = {sliced, window_q[WB-1:1]};

  // Preamble rises and access address bits are taken from the window after the new bit.
  always_comb begin
    rise_cnt = '0;
    for (int c = 0; c < ble_pd_pkg::PREAMBLE_PAIRS; c++) begin
      rise_cnt = rise_cnt + {3'b000, window_d[2*c+2] & ~window_d[2*c]};
    end
    for (int k = 0; k < 32; k++) begin
      aa_bits[k] = window_d[ble_pd_pkg::AA_OFFSET + 2*k];
    end
  end

  assign slice_o.sliced = sliced;
  assign slice_o.start  = (rise_cnt == 4'(ble_pd_pkg::PREAMBLE_RISES)) &&
                          (aa_bits == access_address_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      window_q <= '0;
    end else if (step_i) begin
      prev_q   <= prev_d;
      window_q <= window_d;
    end
  end

endmodule

// File: design/ble_pd_collector.sv
module ble_pd_collector #(
  parameter int unsigned PAYLOAD_BYTES = ble_pd_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  ble_pd_pkg::ble_pd_slice_t  slice_i,
  input  logic [23:0]                crc_initial_i,
  input  logic [5:0]                 channel_index_i,
  output ble_pd_pkg::ble_pd_result_t result_o
);

  localparam int unsigned TOTAL_BYTES = PAYLOAD_BYTES + ble_pd_pkg::CRC_TAIL_BYTES;
  localparam int unsigned CNT_W       = $clog2(TOTAL_BYTES * 8);
  localparam int unsigned BYTE_W      = CNT_W - 3;
  localparam logic [BYTE_W-1:0] PAYLOAD_IDX = BYTE_W'(PAYLOAD_BYTES);
  localparam logic [BYTE_W-1:0] LAST_IDX    = BYTE_W'(TOTAL_BYTES - 1);
  localparam logic [BYTE_W-1:0] SEQ_FIRST   = BYTE_W'(ble_pd_pkg::SEQ_FIRST_BYTE);
  localparam logic [BYTE_W-1:0] SEQ_LAST    = BYTE_W'(ble_pd_pkg::SEQ_LAST_BYTE);
  localparam logic [23:0]       POLY_SHR    = ble_pd_pkg::CRC_POLY[24:1];

  logic              collecting_q, collecting_d;
  logic              sym_q, sym_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        lfsr_q, lfsr_d;
  logic [23:0]       crc_q, crc_d;
  logic [7:0]        byte_q, byte_d;
  logic              mismatch_q, mismatch_d;
  logic [31:0]       seq_q, seq_d;

  logic [BYTE_W-1:0] byte_no;
  logic [BYTE_W-1:0] tail_no;
  logic              d_bit;
  logic [7:0]        lfsr_x;
  logic [7:0]        crc_byte;
  logic              is_last;

  assign byte_no = cnt_q[CNT_W-1:3];
  assign tail_no = byte_no - PAYLOAD_IDX;
  assign d_bit   = slice_i.sliced ^ lfsr_q[0];
  assign lfsr_x  = lfsr_q[0] ? (lfsr_q ^ ble_pd_pkg::LFSR_TAP) : lfsr_q;
  assign is_last = (byte_no == LAST_IDX);

  always_comb begin
    case (tail_no[1:0])
      2'd0:    crc_byte = crc_q[7:0];
      2'd1:    crc_byte = crc_q[15:8];
      2'd2:    crc_byte = crc_q[23:16];
      default: crc_byte = 8'h00;
    endcase
  end

  always_comb begin
    collecting_d = collecting_q;
    sym_d        = sym_q;
    cnt_d        = cnt_q;
    lfsr_d       = lfsr_q;
    crc_d        = crc_q;
    byte_d       = byte_q;
    mismatch_d   = mismatch_q;
    seq_d        = seq_q;
    result_o     = '0;
    if (!collecting_q) begin
      if (slice_i.start) begin
        collecting_d = 1'b1;
        sym_d        = 1'b0;
        cnt_d        = '0;
        lfsr_d       = ble_pd_pkg::LFSR_SEED_BIT |
                       {2'b00, channel_index_i & ble_pd_pkg::CHANNEL_MASK};
        crc_d        = crc_initial_i;
        byte_d       = '0;
        mismatch_d   = 1'b0;
        seq_d        = '0;
      end
    end else if (!sym_q) begin
      sym_d = 1'b1;
    end else begin
      sym_d  = 1'b0;
      lfsr_d = {1'b0, lfsr_x[7:1]};
      if (byte_no < PAYLOAD_IDX) begin
        crc_d = {1'b0, crc_q[23:1]} ^ ((crc_q[0] ^ d_bit) ? POLY_SHR : 24'h000000);
      end
      byte_d = {d_bit, byte_q[7:1]};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q[2:0] == 3'd7) begin
        if (byte_no >= SEQ_FIRST && byte_no <= SEQ_LAST) begin
          seq_d = {seq_q[23:0], byte_d};
        end
        if (byte_no >= PAYLOAD_IDX && crc_byte != byte_d) begin
          mismatch_d = 1'b1;
        end
        result_o.valid      = 1'b1;
        result_o.data_byte  = byte_d;
        result_o.byte_index = 6'(byte_no);
        if (is_last) begin
          collecting_d            = 1'b0;
          cnt_d                   = '0;
          result_o.last_of_packet = 1'b1;
          result_o.crc_ok         = !mismatch_d;
          result_o.seq_number     = seq_d;
          result_o.seq_valid      = !mismatch_d && (|seq_d) &&
                                    !(|seq_d[31:ble_pd_pkg::SEQ_RANGE_BITS]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      sym_q        <= 1'b0;
      cnt_q        <= '0;
      lfsr_q       <= ble_pd_pkg::LFSR_SEED_BIT |
                      {2'b00, ble_pd_pkg::CHANNEL_INDEX_RESET & ble_pd_pkg::CHANNEL_MASK};
      crc_q        <= ble_pd_pkg::CRC_INITIAL_RESET;
      byte_q       <= '0;
      mismatch_q   <= 1'b0;
      seq_q        <= '0;
    end else if (step_i) begin
      collecting_q <= collecting_d;
      sym_q        <= sym_d;
      cnt_q        <= cnt_d;
      lfsr_q       <= lfsr_d;
      crc_q        <= crc_d;
      byte_q       <= byte_d;
      mismatch_q   <= mismatch_d;
      seq_q        <= seq_d;
    end
  end

endmodule

// File: design/ble_packet_deframer_core.sv
// Link-layer deframer for fixed-length packets. Each input request carries one phase sample
// at two samples per symbol; the block slices a bit per sample, hunts for the preamble and
// access address, then dewhitens every second sample, checks CRC-24 over the payload and
// sends one output request per packet byte, the last CRC byte flagged by tlast together with
// the CRC verdict and sequence number. One sample is taken every cycle while the output side
// keeps up. An accepted sample is held in the input register and is then run through the
// single-pass update of the slicer and collector state, so the byte that it completes is
// written to the result register, from which it leaves when the output side takes it.
// A stalled output holds the input side once the input register is full.
`include "ble_packet_deframer_core_defines.svh"

module ble_packet_deframer_core #(
  parameter int unsigned PAYLOAD_BYTES = ble_pd_pkg::PAYLOAD_BYTES_DEF,
  parameter int unsigned PHASE_BITS    = ble_pd_pkg::PHASE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [ble_pd_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [ble_pd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // sample_phase
  input  logic [((PHASE_BITS+7)/8)*8-1:0]        s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // data_byte, byte_index, seq_number, zero fill
  output logic [47:0]                            m_axis_tdata_o,
  output logic                                   m_axis_tlast_o,
  // crc_ok, seq_valid
  output logic [1:0]                             m_axis_tuser_o
);

  localparam int unsigned TOTAL_BYTES = PAYLOAD_BYTES + ble_pd_pkg::CRC_TAIL_BYTES;

  logic [31:0] access_address_q;
  logic [23:0] crc_initial_q;
  logic [5:0]  channel_index_q;

  logic                  in_valid_q;
  logic [PHASE_BITS-1:0] in_phase_q;
  logic                  advance;
  logic                  step;

  ble_pd_pkg::ble_pd_slice_t  slice;
  ble_pd_pkg::ble_pd_result_t result;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [5:0]  out_index_q;
  logic        out_last_q;
  logic        out_ok_q;
  logic [31:0] out_seq_q;
  logic        out_seq_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_address_q <= ble_pd_pkg::ACCESS_ADDRESS_RESET;
      crc_initial_q    <= ble_pd_pkg::CRC_INITIAL_RESET;
      channel_index_q  <= ble_pd_pkg::CHANNEL_INDEX_RESET;
    end else if (cfg_we_i) begin
      unique case (ble_pd_pkg::ble_pd_cfg_e'(cfg_index_i))
        ble_pd_pkg::CFG_ACCESS_ADDRESS: access_address_q <= cfg_data_i[31:0];
        ble_pd_pkg::CFG_CRC_INITIAL:    crc_initial_q    <= cfg_data_i[23:0];
        ble_pd_pkg::CFG_CHANNEL_INDEX:  channel_index_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_phase_q <= s_axis_tdata_i[PHASE_BITS-1:0];
    end
  end

  ble_pd_slicer #(
    .PHASE_BITS(PHASE_BITS)
  ) u_slicer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .phase_i         (in_phase_q),
    .access_address_i(access_address_q),
    .slice_o         (slice)
  );

  ble_pd_collector #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_collector (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .slice_i        (slice),
    .crc_initial_i  (crc_initial_q),
    .channel_index_i(channel_index_q),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && result.valid) begin
      out_byte_q      <= result.data_byte;
      out_index_q     <= result.byte_index;
      out_last_q      <= result.last_of_packet;
      out_ok_q        <= result.crc_ok;
      out_seq_q       <= result.seq_number;
      out_seq_valid_q <= result.seq_valid;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_seq_q, out_index_q, out_byte_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = {out_seq_valid_q, out_ok_q};

  `BPD_ASSERT_IMP(a_seq_valid_on_last, m_axis_tvalid_o && m_axis_tuser_o[1],
                  m_axis_tlast_o && m_axis_tuser_o[0], "seq_valid without CRC pass on last byte")
  `BPD_ASSERT_IMP(a_last_index, m_axis_tvalid_o && m_axis_tlast_o,
                  m_axis_tdata_o[13:8] == 6'(TOTAL_BYTES - 1), "last byte at wrong index")
  `BPD_ASSERT_NXT(a_result_shown, step && result.valid, m_axis_tvalid_o,
                  "finished byte not presented")
  `BPD_ASSERT_IMP(a_stall_holds_step, m_axis_tvalid_o && !m_axis_tready_i, !step,
                  "sample processed while result is stalled")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned N_PAYLOAD    = ble_pd_pkg::PAYLOAD_BYTES_DEF;
  localparam int unsigned N_BYTES      = ble_pd_pkg::PAYLOAD_BYTES_DEF +
                                         ble_pd_pkg::CRC_TAIL_BYTES;
  localparam int unsigned WIN_BITS     = ble_pd_pkg::WINDOW_BITS;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned N_PHASES     = 2;
  localparam logic [ble_pd_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e                          kind;
    logic [ble_pd_pkg::CFG_INDEX_W-1:0] index;
    logic [31:0]                        value;
  } dir_row_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic        last_of_packet;
    logic        crc_ok;
    logic [31:0] seq_number;
    logic        seq_valid;
  } rx_byte_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we;
  logic [ble_pd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ble_pd_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                               s_valid;
  logic                               s_axis_tready_o;
  logic [15:0]                        s_data;
  logic                               m_axis_tvalid_o;
  logic                               m_ready;
  logic [47:0]                        m_axis_tdata_o;
  logic                               m_axis_tlast_o;
  logic [1:0]                         m_axis_tuser_o;

  ble_packet_deframer_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  logic [31:0] cfg_aa  = ble_pd_pkg::ACCESS_ADDRESS_RESET;
  logic [23:0] cfg_crc = ble_pd_pkg::CRC_INITIAL_RESET;
  logic [5:0]  cfg_ch  = ble_pd_pkg::CHANNEL_INDEX_RESET;

  logic [15:0]         last_phase = '0;
  logic [WIN_BITS-1:0] slice_win  = '0;
  logic                in_packet  = 1'b0;
  logic                odd_sample = 1'b0;
  logic [8:0]          bit_pos    = '0;
  logic [7:0]          white_lfsr = ble_pd_pkg::LFSR_SEED_BIT |
                                    {2'b00, ble_pd_pkg::CHANNEL_INDEX_RESET};
  logic [23:0]         crc_acc    = ble_pd_pkg::CRC_INITIAL_RESET;
  logic [7:0]          byte_acc   = '0;
  logic                crc_bad    = 1'b0;
  logic [31:0]         seq_acc    = '0;

  rx_byte_t byte_q [$];

  logic [15:0] gen_phase = '0;
  bit          idle_free = 1'b0;
  int          fails = 0;
  int          samples_in = 0;
  int          bytes_out = 0;
  int          packets_seen = 0;
  int          crc_pass = 0;
  int          seq_pass = 0;
  int          reg_writes = 0;
  int          cycles = 0;
  dir_row_t    dir_rows [14];

  always #1 clk_i = ~clk_i;

  function automatic logic [8:0] whiten_next(input logic [7:0] lfsr);
    logic [7:0] nxt;
    nxt = lfsr[0] ? (lfsr ^ ble_pd_pkg::LFSR_TAP) : lfsr;
    return {lfsr[0], 1'b0, nxt[7:1]};
  endfunction

  function automatic logic [23:0] crc_next(input logic [23:0] crc, input logic d);
    logic [24:0] tmp;
    tmp = {1'b0, crc} ^ ((crc[0] ^ d) ? ble_pd_pkg::CRC_POLY : 25'd0);
    return tmp[24:1];
  endfunction

  task automatic absorb_sample(input logic [15:0] phase);
    logic [15:0] diff;
    logic        b;
    logic        d;
    logic [8:0]  wn;
    logic [5:0]  byte_no;
    logic [31:0] aa;
    int          rises;
    rx_byte_t    r;
    diff = phase - last_phase;
    b = (diff != 16'd0) && !diff[15];
    last_phase = phase;
    slice_win = {b, slice_win[WIN_BITS-1:1]};
    if (!in_packet) begin
      rises = 0;
      aa = '0;
      for (int c = 0; c < ble_pd_pkg::PREAMBLE_PAIRS; c++) begin
        if (slice_win[2*c+2] && !slice_win[2*c]) rises++;
      end
      for (int c = 0; c < 32; c++) aa[c] = slice_win[ble_pd_pkg::AA_OFFSET + 2*c];
      if (rises == ble_pd_pkg::PREAMBLE_RISES && aa == cfg_aa) begin
        in_packet = 1'b1;
        odd_sample = 1'b0;
        bit_pos = '0;
        white_lfsr = ble_pd_pkg::LFSR_SEED_BIT | {2'b00, cfg_ch};
        crc_acc = cfg_crc;
        byte_acc = '0;
        crc_bad = 1'b0;
        seq_acc = '0;
      end
    end else if (!odd_sample) begin
      odd_sample = 1'b1;
    end else begin
      odd_sample = 1'b0;
      byte_no = bit_pos[8:3];
      wn = whiten_next(white_lfsr);
      white_lfsr = wn[7:0];
      d = b ^ wn[8];
      if (byte_no < N_PAYLOAD) crc_acc = crc_next(crc_acc, d);
      byte_acc = {d, byte_acc[7:1]};
      if (bit_pos[2:0] == 3'd7) begin
        if (byte_no >= ble_pd_pkg::SEQ_FIRST_BYTE && byte_no <= ble_pd_pkg::SEQ_LAST_BYTE) begin
          seq_acc = {seq_acc[23:0], byte_acc};
        end
        if (byte_no >= N_PAYLOAD && crc_acc[8*(byte_no-N_PAYLOAD) +: 8] != byte_acc) begin
          crc_bad = 1'b1;
        end
        r = '0;
        r.data_byte = byte_acc;
        r.byte_index = byte_no;
        if (byte_no + 1 >= N_BYTES) begin
          r.last_of_packet = 1'b1;
          r.crc_ok = !crc_bad;
          r.seq_number = seq_acc;
          r.seq_valid = !crc_bad && seq_acc != 0 &&
                        seq_acc[31:ble_pd_pkg::SEQ_RANGE_BITS] == 0;
          in_packet = 1'b0;
        end
        byte_q.insert(byte_q.size(), r);
      end
      bit_pos = in_packet ? bit_pos + 9'd1 : 9'd0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_byte();
    rx_byte_t want;
    rx_byte_t got;
    got.data_byte = m_axis_tdata_o[7:0];
    got.byte_index = m_axis_tdata_o[13:8];
    got.seq_number = m_axis_tdata_o[45:14];
    got.last_of_packet = m_axis_tlast_o;
    got.crc_ok = m_axis_tuser_o[0];
    got.seq_valid = m_axis_tuser_o[1];
    if (byte_q.size() == 0) begin
      $error("output byte 0x%0h at index %0d with nothing pending", got.data_byte,
             got.byte_index);
      fails++;
    end else begin
      want = byte_q.pop_front();
      check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      check_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
      check_field("last_of_packet", 32'(want.last_of_packet), 32'(got.last_of_packet));
      check_field("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok));
      check_field("seq_number", want.seq_number, got.seq_number);
      check_field("seq_valid", 32'(want.seq_valid), 32'(got.seq_valid));
      bytes_out++;
      if (want.last_of_packet) begin
        packets_seen++;
        if (want.crc_ok) crc_pass++;
        if (want.seq_valid) seq_pass++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_valid && s_axis_tready_o) begin
      absorb_sample(s_data);
      samples_in++;
    end
    if (rst_ni && m_axis_tvalid_o && m_ready) check_byte();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[ble_packet_deframer_core] ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) m_ready <= idle_free || ($urandom_range(99) >= 15);

  task automatic push_sample(input logic [15:0] phase);
    @(negedge clk_i);
    while (!idle_free && $urandom_range(99) < 15) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= phase;
    gen_phase = phase;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic push_bit(input logic b);
    logic [15:0] step;
    if (b) begin
      step = 16'($urandom_range(1, 32767));
    end else begin
      case ($urandom_range(3))
        0: step = 16'h0000;
        1: step = 16'h8000;
        default: step = 16'($urandom_range(32768, 65535));
      endcase
    end
    push_sample(gen_phase + step);
  endtask

  task automatic push_header(input logic [7:0] pre, input logic [31:0] aa);
    for (int c = 0; c < 8; c++) repeat (2) push_bit(pre[c]);
    for (int c = 0; c < 32; c++) repeat (2) push_bit(aa[c]);
  endtask

  task automatic push_decoy();
    logic [31:0] aa;
    logic [7:0]  pre;
    int          k;
    aa = cfg_aa;
    pre = 8'hAA;
    if ($urandom_range(1)) begin
      k = $urandom_range(31);
      aa[k] = ~aa[k];
    end else begin
      pre = 8'h0A;
    end
    push_header(pre, aa);
  endtask

  task automatic push_packet(input logic [31:0] seq, input bit corrupt);
    logic [7:0]  pkt [N_BYTES];
    logic [23:0] crc;
    logic [7:0]  lfsr;
    logic [8:0]  wn;
    int          bi;
    int          bk;
    for (int i = 0; i < N_PAYLOAD; i++) pkt[i] = 8'($urandom);
    for (int i = 0; i < 4; i++) pkt[ble_pd_pkg::SEQ_FIRST_BYTE + i] = seq[8*(3-i) +: 8];
    crc = cfg_crc;
    for (int i = 0; i < N_PAYLOAD; i++) begin
      for (int k = 0; k < 8; k++) crc = crc_next(crc, pkt[i][k]);
    end
    for (int j = 0; j < ble_pd_pkg::CRC_TAIL_BYTES; j++) pkt[N_PAYLOAD + j] = crc[8*j +: 8];
    if (corrupt) begin
      bi = $urandom_range(N_BYTES - 1);
      bk = $urandom_range(7);
      pkt[bi][bk] = ~pkt[bi][bk];
    end
    push_header(8'hAA, cfg_aa);
    lfsr = ble_pd_pkg::LFSR_SEED_BIT | {2'b00, cfg_ch};
    for (int i = 0; i < N_BYTES; i++) begin
      for (int k = 0; k < 8; k++) begin
        wn = whiten_next(lfsr);
        lfsr = wn[7:0];
        push_bit(pkt[i][k] ^ wn[8]);
        push_bit(1'($urandom_range(1)));
      end
    end
  endtask

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) push_sample(gen_phase);
      else push_sample(16'($urandom));
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ble_pd_pkg::CFG_INDEX_W-1:0] index,
                           input logic [31:0] value);
    settle();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (index)
      ble_pd_pkg::CFG_ACCESS_ADDRESS: cfg_aa = value;
      ble_pd_pkg::CFG_CRC_INITIAL:    cfg_crc = value[23:0];
      ble_pd_pkg::CFG_CHANNEL_INDEX:  cfg_ch = value[5:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  initial begin
    logic [31:0] hi;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_valid = 1'b0;
    s_data = '0;
    m_ready = 1'b0;
    dir_rows = '{
      '{ROW_SAMPLE, '0, 32'h0000},
      '{ROW_SAMPLE, '0, 32'h8000},
      '{ROW_SAMPLE, '0, 32'h0000},
      '{ROW_SAMPLE, '0, 32'h7FFF},
      '{ROW_SAMPLE, '0, 32'h8000},
      '{ROW_SAMPLE, '0, 32'hFFFF},
      '{ROW_SAMPLE, '0, 32'h0000},
      '{ROW_SAMPLE, '0, 32'hFFFF},
      '{ROW_SAMPLE, '0, 32'hFFFF},
      '{ROW_CONFIG, CFG_UNMAPPED, 32'hFFFF_FFFF},
      '{ROW_CONFIG, ble_pd_pkg::CFG_CHANNEL_INDEX, 32'hFFFF_FFE7},
      '{ROW_CONFIG, ble_pd_pkg::CFG_CHANNEL_INDEX, {26'd0, ble_pd_pkg::CHANNEL_INDEX_RESET}},
      '{ROW_SAMPLE, '0, 32'h5555},
      '{ROW_SAMPLE, '0, 32'hAAAA}
    };
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Only hunting happens here, so the block must stay silent.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CONFIG) write_reg(dir_rows[i].index, dir_rows[i].value);
      else push_sample(dir_rows[i].value[15:0]);
    end
    settle();
    if (bytes_out != 0) begin
      $error("bytes_out: expected 0, got %0d", bytes_out);
      fails++;
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      hi = $urandom;
      if (ph == 0) begin
        write_reg(ble_pd_pkg::CFG_ACCESS_ADDRESS, 32'h0000_0000);
        write_reg(ble_pd_pkg::CFG_CRC_INITIAL, {hi[7:0], 24'h000000});
        write_reg(ble_pd_pkg::CFG_CHANNEL_INDEX, {hi[31:6], 6'd0});
      end else begin
        write_reg(ble_pd_pkg::CFG_ACCESS_ADDRESS, $urandom);
        write_reg(ble_pd_pkg::CFG_CRC_INITIAL, $urandom);
        write_reg(ble_pd_pkg::CFG_CHANNEL_INDEX, $urandom_range(39));
      end
      idle_free = (ph == 0);
      push_noise($urandom_range(5, 15));
      if (ph == N_PHASES - 1) push_packet($urandom_range(1, 32'h000F_FFFF), 1'b0);
      else push_decoy();
      push_noise($urandom_range(5, 15));
    end
    idle_free = 1'b0;

    settle();
    $display("Fed %0d phase samples; checked %0d bytes from %0d packets, %0d with good CRC,",
             samples_in, bytes_out, packets_seen, crc_pass);
    $display("%0d with a valid sequence number, after %0d register writes.", seq_pass,
             reg_writes);
    if (fails == 0) begin
      $display("[ble_packet_deframer_core] OK");
    end else begin
      $display("[ble_packet_deframer_core] ERROR");
    end
    $finish;
  end

endmodule
